>>> rtl/twisp_pkg.sv
// Shared types and constants for the two-wire frame master.
// Holds the input beat and result beat structs; no dependencies.
package twisp_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CountW = 4;
  localparam logic [CountW-1:0] MaxFrameBytes = 4'd8;
  localparam logic ReqTick = 1'b0;
  localparam logic ReqFrame = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [DataW-1:0] tx_data;
    logic [CountW-1:0] tx_count;
    logic [CountW-1:0] rx_count;
    logic             sda_in;
  } item_t;

  typedef struct packed {
    logic             clk_out;
    logic             sda_out;
    logic             sda_drive;
    logic             busy_res;
    logic             frame_done;
    logic [DataW-1:0] rx_data;
    logic             rejected;
  } result_t;

  function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] c);
    clamp_count = (c > MaxFrameBytes) ? MaxFrameBytes : c;
  endfunction

endpackage

>>> rtl/twisp_in_stage.sv
// Input register stage of the two-wire frame master.
// Captures one beat and holds it until the core takes it; uses twisp_pkg.
module twisp_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  twisp_pkg::item_t item_i,
  output logic            valid_o,
  output twisp_pkg::item_t item_o,
  input  logic            take_i
);

  logic             valid_q;
  logic             valid_d;
  twisp_pkg::item_t item_q;
  logic             load;

  assign stall_o = valid_q && !take_i;
  assign load    = valid_i && !stall_o;
  assign valid_d = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> rtl/twisp_core.sv
// Frame sequencer and result register of the two-wire frame master.
// Holds the pin-phase state, applies one beat per cycle unless stalled; uses twisp_pkg.
module twisp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  twisp_pkg::item_t   item_i,
  output logic               take_o,
  output logic               valid_o,
  input  logic               stall_i,
  output twisp_pkg::result_t result_o
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_A = 4'd1,
    PH_START_B = 4'd2,
    PH_START_C = 4'd3,
    PH_START_D = 4'd4,
    PH_TX_LOW  = 4'd5,
    PH_TX_HIGH = 4'd6,
    PH_TX_TAIL = 4'd7,
    PH_RX_LOW  = 4'd8,
    PH_RX_HIGH = 4'd9,
    PH_RX_TAIL = 4'd10,
    PH_STOP_A  = 4'd11,
    PH_STOP_B  = 4'd12,
    PH_STOP_C  = 4'd13,
    PH_STOP_D  = 4'd14
  } phase_e;

  phase_e phase_q, phase_d;
  logic [2:0] bit_q, bit_d;
  logic [twisp_pkg::CountW-1:0] send_q, send_d, read_q, read_d;
  logic [twisp_pkg::DataW-1:0] tx_sh_q, tx_sh_d, rx_sh_q, rx_sh_d;
  logic clk_q, clk_d, sda_q, sda_d, drv_q, drv_d;
  logic done, rej, busy, take, out_valid_q;
  twisp_pkg::result_t result_q, result_d;

  assign busy   = (phase_q != PH_IDLE);
  assign take   = valid_i && (!out_valid_q || !stall_i);
  assign take_o = (!out_valid_q || !stall_i);

  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    send_d  = send_q;
    read_d  = read_q;
    tx_sh_d = tx_sh_q;
    rx_sh_d = rx_sh_q;
    clk_d   = clk_q;
    sda_d   = sda_q;
    drv_d   = drv_q;
    done    = 1'b0;
    rej     = 1'b0;
    if (item_i.req_type == twisp_pkg::ReqFrame) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        tx_sh_d = item_i.tx_data;
        send_d  = twisp_pkg::clamp_count(item_i.tx_count);
        read_d  = twisp_pkg::clamp_count(item_i.rx_count);
        rx_sh_d = '0;
        bit_d   = '0;
        phase_d = PH_START_A;
      end
    end else if (busy) begin
      case (phase_q)
        PH_START_A: begin
          sda_d = 1'b1;
          drv_d = 1'b1;
          phase_d = PH_START_B;
        end
        PH_START_B: begin
          clk_d = 1'b1;
          phase_d = PH_START_C;
        end
        PH_START_C: begin
          sda_d = 1'b0;
          phase_d = PH_START_D;
        end
        PH_START_D: begin
          clk_d = 1'b0;
          bit_d = '0;
          if (send_q != '0) begin
            phase_d = PH_TX_LOW;
          end else if (read_q != '0) begin
            phase_d = PH_RX_LOW;
          end else begin
            phase_d = PH_STOP_A;
          end
        end
        PH_TX_LOW: begin
          clk_d = 1'b0;
          drv_d = 1'b1;
          sda_d = tx_sh_q[twisp_pkg::DataW-1];
          phase_d = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          clk_d = 1'b1;
          tx_sh_d = {tx_sh_q[twisp_pkg::DataW-2:0], 1'b0};
          if (bit_q == 3'd7) begin
            bit_d = '0;
            phase_d = PH_TX_TAIL;
          end else begin
            bit_d = bit_q + 3'd1;
            phase_d = PH_TX_LOW;
          end
        end
        PH_TX_TAIL: begin
          clk_d = 1'b0;
          sda_d = 1'b0;
          drv_d = 1'b1;
          if (send_q != '0) begin
            send_d = send_q - 4'd1;
          end
          if (send_d != '0) begin
            phase_d = PH_TX_LOW;
          end else if (read_q != '0) begin
            phase_d = PH_RX_LOW;
          end else begin
            phase_d = PH_STOP_A;
          end
        end
        PH_RX_LOW: begin
          drv_d = 1'b0;
          clk_d = 1'b0;
          phase_d = PH_RX_HIGH;
        end
        PH_RX_HIGH: begin
          clk_d = 1'b1;
          rx_sh_d = {rx_sh_q[twisp_pkg::DataW-2:0], item_i.sda_in};
          if (bit_q == 3'd7) begin
            bit_d = '0;
            phase_d = PH_RX_TAIL;
          end else begin
            bit_d = bit_q + 3'd1;
            phase_d = PH_RX_LOW;
          end
        end
        PH_RX_TAIL: begin
          clk_d = 1'b0;
          drv_d = 1'b1;
          sda_d = 1'b0;
          if (read_q != '0) begin
            read_d = read_q - 4'd1;
          end
          phase_d = (read_d != '0) ? PH_RX_LOW : PH_STOP_A;
        end
        PH_STOP_A: begin
          clk_d = 1'b0;
          phase_d = PH_STOP_B;
        end
        PH_STOP_B: begin
          sda_d = 1'b0;
          drv_d = 1'b1;
          phase_d = PH_STOP_C;
        end
        PH_STOP_C: begin
          clk_d = 1'b1;
          phase_d = PH_STOP_D;
        end
        PH_STOP_D: begin
          sda_d = 1'b1;
          drv_d = 1'b1;
          done = 1'b1;
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end else begin
      phase_d = PH_IDLE;
    end
  end

  always_comb begin
    result_d.clk_out    = clk_d;
    result_d.sda_out    = sda_d;
    result_d.sda_drive  = drv_d;
    result_d.busy_res   = (phase_d != PH_IDLE);
    result_d.frame_done = done;
    result_d.rx_data    = rx_sh_d;
    result_d.rejected   = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_q       <= '0;
      send_q      <= '0;
      read_q      <= '0;
      tx_sh_q     <= '0;
      rx_sh_q     <= '0;
      clk_q       <= 1'b1;
      sda_q       <= 1'b1;
      drv_q       <= 1'b1;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        bit_q   <= bit_d;
        send_q  <= send_d;
        read_q  <= read_d;
        tx_sh_q <= tx_sh_d;
        rx_sh_q <= rx_sh_d;
        clk_q   <= clk_d;
        sda_q   <= sda_d;
        drv_q   <= drv_d;
        result_q <= result_d;
        out_valid_q <= 1'b1;
      end else if (!stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = result_q;

endmodule

>>> rtl/two_wire_isp_frame_master.sv
// Top level of the two-wire frame master; instantiates twisp_in_stage and twisp_core.
// Uses the beat and result types of twisp_pkg.
//
// Each input beat is either one timing tick or a frame request, and each gives one
// result beat. A beat is held in the input register, then applied to the sequencer
// state, whose result beat is held in the result register; one beat is taken every
// cycle while the output side is not stalled.
// The sequencer state is a single register set updated once per beat, which is what
// allows consecutive ticks to follow each other without gaps.
module two_wire_isp_frame_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [63:0] tx_data_i,
  input  logic [3:0]  tx_count_i,
  input  logic [3:0]  rx_count_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        clk_out_o,
  output logic        sda_out_o,
  output logic        sda_drive_o,
  output logic        busy_res_o,
  output logic        frame_done_o,
  output logic [63:0] rx_data_o,
  output logic        rejected_o
);

  twisp_pkg::item_t   item_in;
  twisp_pkg::item_t   item_reg;
  twisp_pkg::result_t result;
  logic               item_valid;
  logic               take;

  assign item_in.req_type = req_type_i;
  assign item_in.tx_data  = tx_data_i;
  assign item_in.tx_count = tx_count_i;
  assign item_in.rx_count = rx_count_i;
  assign item_in.sda_in   = sda_in_i;

  twisp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .item_i  (item_in),
    .valid_o (item_valid),
    .item_o  (item_reg),
    .take_i  (take)
  );

  twisp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (item_valid),
    .item_i   (item_reg),
    .take_o   (take),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .result_o (result)
  );

  assign clk_out_o    = result.clk_out;
  assign sda_out_o    = result.sda_out;
  assign sda_drive_o  = result.sda_drive;
  assign busy_res_o   = result.busy_res;
  assign frame_done_o = result.frame_done;
  assign rx_data_o    = result.rx_data;
  assign rejected_o   = result.rejected;

endmodule

>>> rtl/twisp_checker.sv
// Port-level checker for the two-wire frame master, bound to the top level.
// Depends only on the top level's ports.
module twisp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        clk_out_o,
  input logic        sda_out_o,
  input logic        sda_drive_o,
  input logic        busy_res_o,
  input logic        frame_done_o,
  input logic [63:0] rx_data_o,
  input logic        rejected_o
);

  // When no frame is in progress, the bus rests with both lines driven high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !busy_res_o) |-> (clk_out_o && sda_out_o && sda_drive_o))
    else $error("idle result beat shows bus not at rest");

  // A finished stop condition leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> !busy_res_o)
    else $error("frame done while still busy");

  // A request is only rejected while a frame is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rejected_o) |-> (busy_res_o && !frame_done_o))
    else $error("request rejected while idle");

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(rx_data_o) && $stable(busy_res_o) && $stable(clk_out_o)))
    else $error("stalled result beat changed");

endmodule

bind two_wire_isp_frame_master twisp_checker u_twisp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .clk_out_o    (clk_out_o),
  .sda_out_o    (sda_out_o),
  .sda_drive_o  (sda_drive_o),
  .busy_res_o   (busy_res_o),
  .frame_done_o (frame_done_o),
  .rx_data_o    (rx_data_o),
  .rejected_o   (rejected_o)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for two_wire_isp_frame_master: directed and random frames,
// ticks and turned-away requests, with random idling on both channels.
// Depends on twisp_pkg for the beat and result types and the frame byte limit.
module testbench;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned BusyBeats = 800;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports = 40;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START_DATA, ST_START_CLK, ST_START_FALL, ST_START_LOW,
    ST_TX_LOW, ST_TX_HIGH, ST_TX_GAP, ST_RX_LOW, ST_RX_HIGH, ST_RX_GAP,
    ST_STOP_LOW, ST_STOP_DATA, ST_STOP_CLK, ST_STOP_RISE
  } seq_e;

  class frame_scoreboard;
    seq_e                seq;
    logic [2:0]          bit_pos;
    logic [3:0]          tx_left;
    logic [3:0]          rx_left;
    logic [63:0]         tx_shift;
    logic [63:0]         rx_shift;
    logic                scl;
    logic                sda;
    logic                sda_en;
    twisp_pkg::result_t  pin_results[$];
    int unsigned         errors;
    int unsigned         beats_checked;
    int unsigned         frames_done;
    int unsigned         turned_away;

    function new();
      seq = ST_IDLE;
      bit_pos = '0;
      tx_left = '0;
      rx_left = '0;
      tx_shift = '0;
      rx_shift = '0;
      scl = 1'b1;
      sda = 1'b1;
      sda_en = 1'b1;
      errors = 0;
      beats_checked = 0;
      frames_done = 0;
      turned_away = 0;
    endfunction

    function bit busy();
      return seq != ST_IDLE;
    endfunction

    function logic [3:0] sat_count(logic [3:0] c);
      return (c > twisp_pkg::MaxFrameBytes) ? twisp_pkg::MaxFrameBytes : c;
    endfunction

    function seq_e after_tx();
      if (tx_left != 0) return ST_TX_LOW;
      if (rx_left != 0) return ST_RX_LOW;
      return ST_STOP_LOW;
    endfunction

    function logic run_phase(logic sda_in);
      logic done;
      done = 1'b0;
      case (seq)
        ST_START_DATA: begin
          sda = 1'b1; sda_en = 1'b1; seq = ST_START_CLK;
        end
        ST_START_CLK: begin
          scl = 1'b1; seq = ST_START_FALL;
        end
        ST_START_FALL: begin
          sda = 1'b0; seq = ST_START_LOW;
        end
        ST_START_LOW: begin
          scl = 1'b0; bit_pos = '0; seq = after_tx();
        end
        ST_TX_LOW: begin
          scl = 1'b0; sda_en = 1'b1; sda = tx_shift[63]; seq = ST_TX_HIGH;
        end
        ST_TX_HIGH: begin
          scl = 1'b1;
          tx_shift = tx_shift << 1;
          if (bit_pos == 3'd7) begin
            bit_pos = '0; seq = ST_TX_GAP;
          end else begin
            bit_pos++; seq = ST_TX_LOW;
          end
        end
        ST_TX_GAP: begin
          scl = 1'b0; sda = 1'b0; sda_en = 1'b1;
          if (tx_left != 0) tx_left--;
          seq = after_tx();
        end
        ST_RX_LOW: begin
          sda_en = 1'b0; scl = 1'b0; seq = ST_RX_HIGH;
        end
        ST_RX_HIGH: begin
          scl = 1'b1;
          rx_shift = {rx_shift[62:0], sda_in};
          if (bit_pos == 3'd7) begin
            bit_pos = '0; seq = ST_RX_GAP;
          end else begin
            bit_pos++; seq = ST_RX_LOW;
          end
        end
        ST_RX_GAP: begin
          scl = 1'b0; sda_en = 1'b1; sda = 1'b0;
          if (rx_left != 0) rx_left--;
          seq = (rx_left != 0) ? ST_RX_LOW : ST_STOP_LOW;
        end
        ST_STOP_LOW: begin
          scl = 1'b0; seq = ST_STOP_DATA;
        end
        ST_STOP_DATA: begin
          sda = 1'b0; sda_en = 1'b1; seq = ST_STOP_CLK;
        end
        ST_STOP_CLK: begin
          scl = 1'b1; seq = ST_STOP_RISE;
        end
        ST_STOP_RISE: begin
          sda = 1'b1; sda_en = 1'b1; done = 1'b1; seq = ST_IDLE;
        end
        default: begin
          seq = ST_IDLE;
        end
      endcase
      return done;
    endfunction

    function void note_beat(twisp_pkg::item_t it);
      twisp_pkg::result_t r;
      logic               done;
      logic               rej;
      done = 1'b0;
      rej = 1'b0;
      if (it.req_type == twisp_pkg::ReqFrame) begin
        if (busy()) begin
          rej = 1'b1;
        end else begin
          tx_shift = it.tx_data;
          tx_left = sat_count(it.tx_count);
          rx_left = sat_count(it.rx_count);
          rx_shift = '0;
          bit_pos = '0;
          seq = ST_START_DATA;
        end
      end else if (busy()) begin
        done = run_phase(it.sda_in);
      end else begin
        seq = ST_IDLE;
      end
      r.clk_out = scl;
      r.sda_out = sda;
      r.sda_drive = sda_en;
      r.busy_res = busy();
      r.frame_done = done;
      r.rx_data = rx_shift;
      r.rejected = rej;
      pin_results.push_back(r);
      if (done) frames_done++;
      if (rej) turned_away++;
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(twisp_pkg::result_t got);
      twisp_pkg::result_t want;
      if (pin_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: result beat with nothing expected, got %h", $time, got);
        return;
      end
      want = pin_results.pop_front();
      beats_checked++;
      compare_field("clk_out", 64'(want.clk_out), 64'(got.clk_out));
      compare_field("sda_out", 64'(want.sda_out), 64'(got.sda_out));
      compare_field("sda_drive", 64'(want.sda_drive), 64'(got.sda_drive));
      compare_field("busy_res", 64'(want.busy_res), 64'(got.busy_res));
      compare_field("frame_done", 64'(want.frame_done), 64'(got.frame_done));
      compare_field("rx_data", want.rx_data, got.rx_data);
      compare_field("rejected", 64'(want.rejected), 64'(got.rejected));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic [63:0] tx_data_i = '0;
  logic [3:0]  tx_count_i = '0;
  logic [3:0]  rx_count_i = '0;
  logic        sda_in_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        clk_out_o;
  logic        sda_out_o;
  logic        sda_drive_o;
  logic        busy_res_o;
  logic        frame_done_o;
  logic [63:0] rx_data_o;
  logic        rejected_o;

  frame_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int unsigned     useful_beats = 0;
  bit              burst = 1'b0;

  two_wire_isp_frame_master u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .tx_data_i   (tx_data_i),
    .tx_count_i  (tx_count_i),
    .rx_count_i  (rx_count_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .clk_out_o   (clk_out_o),
    .sda_out_o   (sda_out_o),
    .sda_drive_o (sda_drive_o),
    .busy_res_o  (busy_res_o),
    .frame_done_o(frame_done_o),
    .rx_data_o   (rx_data_o),
    .rejected_o  (rejected_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still due.", cycle_count,
               sb.pin_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{clk_out_o, sda_out_o, sda_drive_o, busy_res_o, frame_done_o,
                        rx_data_o, rejected_o});
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    forever begin
      repeat ($urandom_range(1, 100)) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat (idle_len()) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
    end
  end

  function automatic logic [3:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 4'($urandom_range(0, 1));
    if (r < 88) return 4'($urandom_range(2, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  function automatic twisp_pkg::item_t make_item(logic req, logic [63:0] data,
                                                 logic [3:0] txc, logic [3:0] rxc,
                                                 logic sda);
    twisp_pkg::item_t it;
    it.req_type = req;
    it.tx_data = data;
    it.tx_count = txc;
    it.rx_count = rxc;
    it.sda_in = sda;
    return it;
  endfunction

  function automatic twisp_pkg::item_t random_item(logic req);
    return make_item(req, {$urandom(), $urandom()}, pick_count(), pick_count(),
                     1'($urandom_range(0, 1)));
  endfunction

  task automatic drive_beat(twisp_pkg::item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= it.req_type;
    tx_data_i <= it.tx_data;
    tx_count_i <= it.tx_count;
    rx_count_i <= it.rx_count;
    sda_in_i <= it.sda_in;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if ((it.req_type == twisp_pkg::ReqFrame) != sb.busy()) useful_beats++;
    sb.note_beat(it);
  endtask

  task automatic pause_sender(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  initial begin
    twisp_pkg::item_t it;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    drive_beat(make_item(twisp_pkg::ReqTick, '1, 4'd15, 4'd15, 1'b1));
    drive_beat(make_item(twisp_pkg::ReqTick, '0, 4'd0, 4'd0, 1'b0));
    drive_beat(make_item(twisp_pkg::ReqFrame, '1, 4'd0, 4'd0, 1'b1));
    repeat (8) drive_beat(make_item(twisp_pkg::ReqTick, '0, 4'd0, 4'd0, 1'b0));
    drive_beat(make_item(twisp_pkg::ReqTick, '1, 4'd8, 4'd8, 1'b1));
    drive_beat(make_item(twisp_pkg::ReqFrame, 64'h8001_0000_0000_0001, 4'd15, 4'd15,
                         1'b0));
    drive_beat(make_item(twisp_pkg::ReqFrame, '1, 4'd8, 4'd8, 1'b1));
    drive_beat(make_item(twisp_pkg::ReqTick, '0, 4'd0, 4'd0, 1'b1));
    drive_beat(make_item(twisp_pkg::ReqTick, '1, 4'd15, 4'd15, 1'b0));

    while (useful_beats < BusyBeats || sb.busy()) begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      if (sb.busy())
        it = random_item(($urandom_range(0, 99) < 3) ? twisp_pkg::ReqFrame
                                                     : twisp_pkg::ReqTick);
      else
        it = random_item(($urandom_range(0, 9) == 0) ? twisp_pkg::ReqTick
                                                     : twisp_pkg::ReqFrame);
      drive_beat(it);
      pause_sender(burst ? 0 : idle_len());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.pin_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d result beats over %0d cycles.", sb.beats_checked, cycle_count);
    $display("Frames completed: %0d, requests turned away while busy: %0d.",
             sb.frames_done, sb.turned_away);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/twisp_pkg.sv
rtl/twisp_in_stage.sv
rtl/twisp_core.sv
rtl/two_wire_isp_frame_master.sv
rtl/twisp_checker.sv
bench/testbench.sv
